@@ rtl/core/tp4a_pkg.sv @@
package tp4a_pkg;

  localparam int MAX_EXTENT = 64;
  localparam int WORD_BITS  = 32;

  localparam int POS_BITS   = (MAX_EXTENT > 1) ? $clog2(MAX_EXTENT) : 1;
  localparam int EXT_BITS   = 7;
  localparam int PERM_BITS  = 2;
  localparam int ADDR_BITS  = 24;
  localparam int S2_BITS    = EXT_BITS;
  localparam int S1_BITS    = 2 * EXT_BITS;
  localparam int S0_BITS    = 3 * EXT_BITS;
  localparam int CFG_INDEX_BITS = 4;
  localparam int CFG_DATA_BITS  = EXT_BITS;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_EXTENT_A = 4'd0,
    REG_EXTENT_B = 4'd1,
    REG_EXTENT_C = 4'd2,
    REG_EXTENT_D = 4'd3,
    REG_PERM_A   = 4'd4,
    REG_PERM_B   = 4'd5,
    REG_PERM_C   = 4'd6,
    REG_PERM_D   = 4'd7
  } cfg_index_t;

  typedef logic [EXT_BITS-1:0] extent_t;
  typedef logic [PERM_BITS-1:0] perm_t;
  typedef logic [POS_BITS-1:0] pos_t;

  // An extent of zero acts as one; anything above the maximum is clamped.
  function automatic extent_t eff_extent(input extent_t e);
    extent_t r;
    r = e;
    if (e == '0) begin
      r = EXT_BITS'(1);
    end else if (32'(e) > MAX_EXTENT) begin
      r = EXT_BITS'(MAX_EXTENT);
    end
    return r;
  endfunction

  function automatic extent_t pick_extent(input extent_t a, input extent_t b,
                                          input extent_t c, input extent_t d,
                                          input perm_t sel);
    extent_t r;
    case (sel)
      2'd0:    r = a;
      2'd1:    r = b;
      2'd2:    r = c;
      default: r = d;
    endcase
    return r;
  endfunction

  function automatic pos_t pick_pos(input pos_t a, input pos_t b, input pos_t c,
                                    input pos_t d, input perm_t sel);
    pos_t r;
    case (sel)
      2'd0:    r = a;
      2'd1:    r = b;
      2'd2:    r = c;
      default: r = d;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/core/tp4a_if.sv @@
interface tp4a_elem_if;
  logic                           valid;
  logic                           ready;
  logic [tp4a_pkg::WORD_BITS-1:0] element_word;

  modport source (output valid, output element_word, input ready);
  modport sink (input valid, input element_word, output ready);
endinterface

interface tp4a_result_if;
  logic                           valid;
  logic                           ready;
  logic [tp4a_pkg::ADDR_BITS-1:0] target_address;
  logic [tp4a_pkg::WORD_BITS-1:0] moved_word;
  logic                           tensor_done;

  modport source (output valid, output target_address, output moved_word,
                  output tensor_done, input ready);
  modport sink (input valid, input target_address, input moved_word,
                input tensor_done, output ready);
endinterface

interface tp4a_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [tp4a_pkg::CFG_INDEX_BITS-1:0] index;
  logic [tp4a_pkg::CFG_DATA_BITS-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

@@ rtl/core/tensor_permute_4d_address_top.sv @@
// Streaming 4-D transpose address generator. Each element beat of a row-major
// input tensor (dimension a slowest, d fastest) yields one result beat with the
// data word unchanged, its index in the axis-permuted output tensor, and a flag
// on the tensor's last element, after which the position counters wrap. Steady
// throughput is one element per cycle while results are taken and no stride
// rebuild is pending; an element passes a product register, then a result
// register. A two-stage multiplier chain rebuilds the strides after each
// write; input waits for it. Configuration writes are always accepted and must
// only happen while no element is in flight; the permutation is not checked.
module tensor_permute_4d_address_top (
  input  logic                 clk,
  input  logic                 rst,
  tp4a_cfg_if.sink             cfg,
  tp4a_elem_if.sink            element,
  tp4a_result_if.source        result
);

  tp4a_pkg::extent_t extent_a, extent_b, extent_c, extent_d;
  tp4a_pkg::perm_t   perm_a, perm_b, perm_c, perm_d;
  tp4a_pkg::pos_t    pos_a, pos_b, pos_c, pos_d;

  logic [tp4a_pkg::S2_BITS-1:0] stride2;
  logic [tp4a_pkg::S1_BITS-1:0] stride1;
  logic [tp4a_pkg::S0_BITS-1:0] stride0;
  logic [1:0]                   stale;

  tp4a_pkg::extent_t eff_a, eff_b, eff_c, eff_d;
  tp4a_pkg::extent_t eff_p1, eff_p2, eff_p3;
  logic last_a, last_b, last_c, last_d, done_now;
  logic accept, p_adv, out_adv;

  // product stage
  logic                           p_valid;
  logic [tp4a_pkg::ADDR_BITS-1:0] prod0, prod1, prod2;
  tp4a_pkg::pos_t                 pos_fast;
  logic [tp4a_pkg::WORD_BITS-1:0] p_word;
  logic                           p_done;

  // result register
  logic                           r_valid;
  logic [tp4a_pkg::ADDR_BITS-1:0] r_addr;
  logic [tp4a_pkg::WORD_BITS-1:0] r_word;
  logic                           r_done;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      extent_a <= tp4a_pkg::EXT_BITS'(1);
      extent_b <= tp4a_pkg::EXT_BITS'(1);
      extent_c <= tp4a_pkg::EXT_BITS'(1);
      extent_d <= tp4a_pkg::EXT_BITS'(1);
      perm_a   <= 2'd0;
      perm_b   <= 2'd1;
      perm_c   <= 2'd2;
      perm_d   <= 2'd3;
    end else if (cfg.valid) begin
      case (tp4a_pkg::cfg_index_t'(cfg.index))
        tp4a_pkg::REG_EXTENT_A: extent_a <= cfg.data;
        tp4a_pkg::REG_EXTENT_B: extent_b <= cfg.data;
        tp4a_pkg::REG_EXTENT_C: extent_c <= cfg.data;
        tp4a_pkg::REG_EXTENT_D: extent_d <= cfg.data;
        tp4a_pkg::REG_PERM_A:   perm_a   <= cfg.data[tp4a_pkg::PERM_BITS-1:0];
        tp4a_pkg::REG_PERM_B:   perm_b   <= cfg.data[tp4a_pkg::PERM_BITS-1:0];
        tp4a_pkg::REG_PERM_C:   perm_c   <= cfg.data[tp4a_pkg::PERM_BITS-1:0];
        tp4a_pkg::REG_PERM_D:   perm_d   <= cfg.data[tp4a_pkg::PERM_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign eff_a = tp4a_pkg::eff_extent(extent_a);
  assign eff_b = tp4a_pkg::eff_extent(extent_b);
  assign eff_c = tp4a_pkg::eff_extent(extent_c);
  assign eff_d = tp4a_pkg::eff_extent(extent_d);

  assign eff_p1 = tp4a_pkg::pick_extent(eff_a, eff_b, eff_c, eff_d, perm_b);
  assign eff_p2 = tp4a_pkg::pick_extent(eff_a, eff_b, eff_c, eff_d, perm_c);
  assign eff_p3 = tp4a_pkg::pick_extent(eff_a, eff_b, eff_c, eff_d, perm_d);

  // Stride chain (stride1, then stride0) settles after the last write; input is held until then.
  always_ff @(posedge clk) begin
    if (rst) begin
      stride2 <= tp4a_pkg::S2_BITS'(1);
      stride1 <= tp4a_pkg::S1_BITS'(1);
      stride0 <= tp4a_pkg::S0_BITS'(1);
      stale   <= 2'd0;
    end else begin
      stride2 <= eff_p3;
      stride1 <= tp4a_pkg::S1_BITS'(eff_p2) * tp4a_pkg::S1_BITS'(eff_p3);
      stride0 <= tp4a_pkg::S0_BITS'(eff_p1) * tp4a_pkg::S0_BITS'(stride1);
      if (cfg.valid) begin
        stale <= 2'd2;
      end else if (stale != 2'd0) begin
        stale <= stale - 2'd1;
      end
    end
  end

  assign last_a = (32'(pos_a) + 1) >= 32'(eff_a);
  assign last_b = (32'(pos_b) + 1) >= 32'(eff_b);
  assign last_c = (32'(pos_c) + 1) >= 32'(eff_c);
  assign last_d = (32'(pos_d) + 1) >= 32'(eff_d);
  assign done_now = last_a && last_b && last_c && last_d;

  assign out_adv = !r_valid || result.ready;
  assign p_adv   = !p_valid || out_adv;
  assign element.ready = p_adv && (stale == 2'd0);
  assign accept  = element.valid && element.ready;

  // Advance position counters, dimension d fastest.
  always_ff @(posedge clk) begin
    if (rst) begin
      pos_a <= '0;
      pos_b <= '0;
      pos_c <= '0;
      pos_d <= '0;
    end else if (accept) begin
      pos_d <= last_d ? '0 : pos_d + tp4a_pkg::POS_BITS'(1);
      if (last_d) begin
        pos_c <= last_c ? '0 : pos_c + tp4a_pkg::POS_BITS'(1);
      end
      if (last_d && last_c) begin
        pos_b <= last_b ? '0 : pos_b + tp4a_pkg::POS_BITS'(1);
      end
      if (last_d && last_c && last_b) begin
        pos_a <= last_a ? '0 : pos_a + tp4a_pkg::POS_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (p_adv) begin
      p_valid <= accept;
    end
    if (accept) begin
      prod0 <= tp4a_pkg::ADDR_BITS'(tp4a_pkg::pick_pos(pos_a, pos_b, pos_c, pos_d, perm_a))
               * tp4a_pkg::ADDR_BITS'(stride0);
      prod1 <= tp4a_pkg::ADDR_BITS'(tp4a_pkg::pick_pos(pos_a, pos_b, pos_c, pos_d, perm_b))
               * tp4a_pkg::ADDR_BITS'(stride1);
      prod2 <= tp4a_pkg::ADDR_BITS'(tp4a_pkg::pick_pos(pos_a, pos_b, pos_c, pos_d, perm_c))
               * tp4a_pkg::ADDR_BITS'(stride2);
      pos_fast <= tp4a_pkg::pick_pos(pos_a, pos_b, pos_c, pos_d, perm_d);
      p_word   <= element.element_word;
      p_done   <= done_now;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid <= 1'b0;
    end else if (out_adv) begin
      r_valid <= p_valid;
    end
    if (out_adv && p_valid) begin
      r_addr <= prod0 + prod1 + prod2 + tp4a_pkg::ADDR_BITS'(pos_fast);
      r_word <= p_word;
      r_done <= p_done;
    end
  end

  assign result.valid          = r_valid;
  assign result.target_address = r_addr;
  assign result.moved_word     = r_word;
  assign result.tensor_done    = r_done;

endmodule

@@ dv/tensor_permute_4d_address_top_tb.sv @@
`timescale 1ns / 100ps

module tensor_permute_4d_address_top_tb;
  import tp4a_pkg::*;

  localparam int CFG_REG_COUNT = 8;
  localparam int RANDOM_ITEMS  = 800;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int DRAIN_CYCLES  = 4;

  typedef struct packed {
    logic [ADDR_BITS-1:0] target_address;
    logic [WORD_BITS-1:0] moved_word;
    logic                 tensor_done;
  } permuted_beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  tp4a_cfg_if    cfg_bus ();
  tp4a_elem_if   elem_bus ();
  tp4a_result_if res_bus ();

  tensor_permute_4d_address_top i_dut (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg_bus),
    .element (elem_bus),
    .result  (res_bus)
  );

  always #5 clk = ~clk;

  // Shadow copy of the block's registers and input position
  extent_t ext_reg [4];
  perm_t   perm_reg [4];
  pos_t    pos_reg [4];

  permuted_beat_t permuted_beats_q [$];

  int          mismatch_count = 0;
  int          cycle_count    = 0;
  int          burst_left     = 0;
  int          gap_max        = 0;
  logic        stall_on       = 1'b0;
  logic [15:0] stall_pattern  = 16'h0000;
  int          pattern_age    = 0;

  function automatic int unsigned clamp_extent(input extent_t e);
    if (e == '0) return 1;
    if (int'(e) > MAX_EXTENT) return MAX_EXTENT;
    return int'(e);
  endfunction

  function automatic logic [WORD_BITS-1:0] pick_word();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return WORD_BITS'($urandom);
    endcase
  endfunction

  task automatic predict_permuted_beat(input logic [WORD_BITS-1:0] word);
    longint unsigned s0, s1, s2, addr;
    permuted_beat_t  beat;
    logic            carry;
    int              i;
    s2 = clamp_extent(ext_reg[perm_reg[3]]);
    s1 = clamp_extent(ext_reg[perm_reg[2]]) * s2;
    s0 = clamp_extent(ext_reg[perm_reg[1]]) * s1;
    addr = 64'(pos_reg[perm_reg[0]]) * s0 + 64'(pos_reg[perm_reg[1]]) * s1
         + 64'(pos_reg[perm_reg[2]]) * s2 + 64'(pos_reg[perm_reg[3]]);
    beat.target_address = addr[ADDR_BITS-1:0];
    beat.moved_word     = word;
    beat.tensor_done    = 1'b1;
    // a counter at or past its extent counts as sitting on its last position
    for (i = 0; i < 4; i++) begin
      if (int'(pos_reg[i]) + 1 < clamp_extent(ext_reg[i])) beat.tensor_done = 1'b0;
    end
    carry = 1'b1;
    for (i = 3; i >= 0; i--) begin
      if (carry) begin
        if (int'(pos_reg[i]) + 1 >= clamp_extent(ext_reg[i])) begin
          pos_reg[i] = '0;
        end else begin
          pos_reg[i] = pos_reg[i] + 1'b1;
          carry = 1'b0;
        end
      end
    end
    permuted_beats_q.push_back(beat);
  endtask

  task automatic store_register(input logic [CFG_INDEX_BITS-1:0] index,
                                input logic [CFG_DATA_BITS-1:0] data);
    if (index <= REG_EXTENT_D) begin
      ext_reg[index - REG_EXTENT_A] = data;
    end else if (index <= REG_PERM_D) begin
      perm_reg[index - REG_PERM_A] = data[PERM_BITS-1:0];
    end
  endtask

  task automatic note_mismatch(input string field, input logic [WORD_BITS-1:0] want_v,
                               input logic [WORD_BITS-1:0] got_v);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("%0t: mismatch on %s: expected 0x%0h, got 0x%0h", $time, field, want_v, got_v);
    end
  endtask

  // Leaves valid high so back-to-back writes need no lowering in between
  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] index,
                           input logic [CFG_DATA_BITS-1:0] data);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= index;
    cfg_bus.data  <= data;
    do @(posedge clk); while (!cfg_bus.ready);
    store_register(index, data);
  endtask

  task automatic write_out_of_range();
    write_reg(CFG_INDEX_BITS'($urandom_range(CFG_REG_COUNT, (1 << CFG_INDEX_BITS) - 1)),
              CFG_DATA_BITS'($urandom));
  endtask

  task automatic send_element(input logic [WORD_BITS-1:0] word);
    if (burst_left == 0) begin
      if (gap_max > 0) begin
        elem_bus.valid <= 1'b0;
        repeat ($urandom_range(1, gap_max)) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    elem_bus.valid        <= 1'b1;
    elem_bus.element_word <= word;
    do @(posedge clk); while (!elem_bus.ready);
    predict_permuted_beat(word);
  endtask

  task automatic wait_for_drain();
    elem_bus.valid <= 1'b0;
    while (permuted_beats_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic configure_shape(input extent_t ea, input extent_t eb, input extent_t ec,
                                 input extent_t ed, input perm_t pa, input perm_t pb,
                                 input perm_t pc, input perm_t pd, input bit stray_write);
    wait_for_drain();
    write_reg(REG_EXTENT_A, ea);
    write_reg(REG_EXTENT_B, eb);
    write_reg(REG_EXTENT_C, ec);
    write_reg(REG_EXTENT_D, ed);
    // upper data bits of a permutation write are don't-care
    write_reg(REG_PERM_A, {(CFG_DATA_BITS-PERM_BITS)'($urandom), pa});
    write_reg(REG_PERM_B, {(CFG_DATA_BITS-PERM_BITS)'($urandom), pb});
    write_reg(REG_PERM_C, {(CFG_DATA_BITS-PERM_BITS)'($urandom), pc});
    write_reg(REG_PERM_D, {(CFG_DATA_BITS-PERM_BITS)'($urandom), pd});
    if (stray_write) write_out_of_range();
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic test_reset_defaults();
    send_element('0);
    send_element('1);
    send_element(WORD_BITS'($urandom));
  endtask

  task automatic test_clamped_extents();
    // zero acts as one, above the maximum clamps; b's clamp shows in the d stride
    configure_shape(7'd3, 7'd127, 7'd0, 7'd2, 2'd2, 2'd3, 2'd1, 2'd0, 1'b0);
    repeat (4) send_element(pick_word());
  endtask

  task automatic test_counter_past_extent();
    // pos_b is left at 2; shrink its extent to 1 under it
    configure_shape(7'd2, 7'd1, 7'd1, 7'd1, 2'd0, 2'd1, 2'd2, 2'd3, 1'b0);
    repeat (2) send_element(pick_word());
  endtask

  task automatic test_repeated_axes();
    configure_shape(7'd2, 7'd3, 7'd2, 7'd64, 2'd3, 2'd3, 2'd0, 2'd3, 1'b1);
    repeat (6) send_element(pick_word());
  endtask

  task automatic test_largest_shape();
    configure_shape(7'd64, 7'd64, 7'd64, 7'd64, 2'd3, 2'd2, 2'd1, 2'd0, 1'b0);
    repeat (6) send_element(pick_word());
  endtask

  task automatic test_random_tensors();
    extent_t ext [4];
    perm_t   prm [4];
    perm_t   t;
    int      i, j, r, size, items, sent;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      for (i = 0; i < 4; i++) begin
        r = $urandom_range(0, 99);
        if (r < 5) ext[i] = '0;
        else if (r < 10) ext[i] = extent_t'($urandom_range(MAX_EXTENT + 1, (1 << EXT_BITS) - 1));
        else if (r < 15) ext[i] = extent_t'(MAX_EXTENT);
        else ext[i] = extent_t'($urandom_range(1, 4));
        prm[i] = perm_t'(i);
      end
      if ($urandom_range(0, 99) < 85) begin
        for (i = 3; i > 0; i--) begin
          j = $urandom_range(0, i);
          t = prm[i];
          prm[i] = prm[j];
          prm[j] = t;
        end
      end else begin
        for (i = 0; i < 4; i++) prm[i] = perm_t'($urandom);
      end
      configure_shape(ext[0], ext[1], ext[2], ext[3], prm[0], prm[1], prm[2], prm[3],
                      $urandom_range(0, 3) == 0);
      size = 1;
      for (i = 0; i < 4; i++) size = size * int'(clamp_extent(ext[i]));
      // whole tensors (sometimes cut short) where they are small, else a partial run that leaves counters mid-way
      if (size <= 96) begin
        items = size * $urandom_range(1, 2);
        if ($urandom_range(0, 4) == 0) items = items - $urandom_range(0, size - 1);
      end else begin
        items = $urandom_range(16, 96);
      end
      gap_max  = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      stall_on = ($urandom_range(0, 2) != 0);
      repeat (items) send_element(pick_word());
      sent = sent + items;
    end
  endtask

  always @(posedge clk) begin
    if (pattern_age == 47) begin
      stall_pattern <= 16'($urandom) & ~(16'h0001 << $urandom_range(0, 15));
      pattern_age   <= 0;
    end else begin
      stall_pattern <= {stall_pattern[0], stall_pattern[15:1]};
      pattern_age   <= pattern_age + 1;
    end
    res_bus.ready <= !stall_on || !stall_pattern[0];
  end

  always @(posedge clk) begin : result_check
    permuted_beat_t want;
    if (!rst && res_bus.valid && res_bus.ready) begin
      if (permuted_beats_q.size() == 0) begin
        note_mismatch("unexpected beat, target_address", '0, res_bus.target_address);
      end else begin
        want = permuted_beats_q.pop_front();
        if (res_bus.target_address !== want.target_address) begin
          note_mismatch("target_address", want.target_address, res_bus.target_address);
        end
        if (res_bus.moved_word !== want.moved_word) begin
          note_mismatch("moved_word", want.moved_word, res_bus.moved_word);
        end
        if (res_bus.tensor_done !== want.tensor_done) begin
          note_mismatch("tensor_done", want.tensor_done, res_bus.tensor_done);
        end
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Some tests failed");
    $finish;
  end

  initial begin
    int i;
    cfg_bus.valid         = 1'b0;
    cfg_bus.index         = '0;
    cfg_bus.data          = '0;
    elem_bus.valid        = 1'b0;
    elem_bus.element_word = '0;
    for (i = 0; i < 4; i++) begin
      ext_reg[i]  = extent_t'(1);
      perm_reg[i] = perm_t'(i);
      pos_reg[i]  = '0;
    end
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    gap_max  = 3;
    stall_on = 1'b1;
    test_reset_defaults();
    test_clamped_extents();
    test_counter_past_extent();
    test_repeated_axes();
    test_largest_shape();
    test_random_tensors();
    wait_for_drain();

    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/tp4a_pkg.sv
rtl/core/tp4a_if.sv
rtl/core/tensor_permute_4d_address_top.sv
dv/tensor_permute_4d_address_top_tb.sv
